### rtl/core/ieil_pkg.sv
// Package of types, constants and codes for the indexed insert/erase list.
`timescale 1ns / 1ps

package ieil_pkg;

  localparam int CAPACITY    = 16;
  localparam int VALUE_WIDTH = 32;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int POS_W = 5;
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [2:0] OP_POP_FRONT  = 3'd2;
  localparam logic [2:0] OP_POP_BACK   = 3'd3;
  localparam logic [2:0] OP_INSERT     = 3'd4;
  localparam logic [2:0] OP_ERASE      = 3'd5;
  localparam logic [2:0] OP_READ       = 3'd6;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  typedef logic [VALUE_WIDTH-1:0] value_t;

  typedef enum logic [1:0] {
    MODE_NONE = 2'd0,
    MODE_INS  = 2'd1,
    MODE_DEL  = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    SEL_HOLD  = 2'd0,
    SEL_NEW   = 2'd1,
    SEL_LEFT  = 2'd2,
    SEL_RIGHT = 2'd3
  } cell_sel_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [CNT_W-1:0] count_nxt;
    mode_t            mode;
    logic [CMP_W-1:0] at;
    logic             do_read;
  } ctl_t;

endpackage

### rtl/core/ieil_cell.sv
// One list cell: holds a single entry and loads from the beat or a neighbor.
`timescale 1ns / 1ps

module ieil_cell (
  input  logic                clk,
  input  ieil_pkg::cell_sel_t sel,
  input  ieil_pkg::value_t    new_val,
  input  ieil_pkg::value_t    left_val,
  input  ieil_pkg::value_t    right_val,
  output ieil_pkg::value_t    q
);

  ieil_pkg::value_t q_r;

  always_ff @(posedge clk) begin
    case (sel)
      ieil_pkg::SEL_NEW:   q_r <= new_val;
      ieil_pkg::SEL_LEFT:  q_r <= left_val;
      ieil_pkg::SEL_RIGHT: q_r <= right_val;
      default:             q_r <= q_r;
    endcase
  end

  assign q = q_r;

endmodule

### rtl/core/ieil_ctrl.sv
// Operation decode: status, next count, shift request and read enable for one beat.
`timescale 1ns / 1ps

module ieil_ctrl (
  input  logic [2:0]                 opcode,
  input  logic [ieil_pkg::POS_W-1:0] position,
  input  logic [ieil_pkg::CNT_W-1:0] count,
  output ieil_pkg::ctl_t             ctl
);

  logic                       full;
  logic                       empty;
  logic [ieil_pkg::CMP_W-1:0] pos_x;
  logic [ieil_pkg::CMP_W-1:0] cnt_x;

  assign full  = (cnt_x >= ieil_pkg::CMP_W'(ieil_pkg::CAPACITY));
  assign empty = (count == '0);
  assign pos_x = ieil_pkg::CMP_W'(position);
  assign cnt_x = ieil_pkg::CMP_W'(count);

  always_comb begin
    ctl.status    = ieil_pkg::ST_OK;
    ctl.count_nxt = count;
    ctl.mode      = ieil_pkg::MODE_NONE;
    ctl.at        = '0;
    ctl.do_read   = 1'b0;
    case (opcode)
      ieil_pkg::OP_PUSH_FRONT, ieil_pkg::OP_PUSH_BACK: begin
        if (full) begin
          ctl.status = ieil_pkg::ST_FULL;
        end else begin
          ctl.mode      = ieil_pkg::MODE_INS;
          ctl.at        = (opcode == ieil_pkg::OP_PUSH_BACK) ? cnt_x : '0;
          ctl.count_nxt = count + 1'b1;
        end
      end
      ieil_pkg::OP_POP_FRONT: begin
        if (empty) begin
          ctl.status = ieil_pkg::ST_EMPTY;
        end else begin
          ctl.mode      = ieil_pkg::MODE_DEL;
          ctl.count_nxt = count - 1'b1;
        end
      end
      ieil_pkg::OP_POP_BACK: begin
        // dropping the tail needs no shift
        if (empty) begin
          ctl.status = ieil_pkg::ST_EMPTY;
        end else begin
          ctl.count_nxt = count - 1'b1;
        end
      end
      ieil_pkg::OP_INSERT: begin
        if (pos_x > cnt_x) begin
          ctl.status = ieil_pkg::ST_RANGE;
        end else if (full) begin
          ctl.status = ieil_pkg::ST_FULL;
        end else begin
          ctl.mode      = ieil_pkg::MODE_INS;
          ctl.at        = pos_x;
          ctl.count_nxt = count + 1'b1;
        end
      end
      ieil_pkg::OP_ERASE: begin
        if (empty) begin
          ctl.status = ieil_pkg::ST_EMPTY;
        end else if (pos_x >= cnt_x) begin
          ctl.status = ieil_pkg::ST_RANGE;
        end else begin
          ctl.mode      = ieil_pkg::MODE_DEL;
          ctl.at        = pos_x;
          ctl.count_nxt = count - 1'b1;
        end
      end
      ieil_pkg::OP_READ: begin
        if (empty) begin
          ctl.status = ieil_pkg::ST_EMPTY;
        end else if (pos_x >= cnt_x) begin
          ctl.status = ieil_pkg::ST_RANGE;
        end else begin
          ctl.do_read = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

### rtl/core/indexed_insert_erase_list_core.sv
// Top level of the indexed insert/erase list: cell row, decode and result register.
//
// Usage: every input beat on in_* carries one list operation (push front/back,
// pop front/back, insert, erase, read at a position). Each accepted beat
// yields exactly one result beat on out_* with the read value (zero unless a
// successful read), the count after the operation and a status code.
// The entries live in a row of cells; an insert or erase moves every later
// cell by one place through its neighbor in the same clock, so the whole
// operation finishes in the cycle the beat is accepted.
// The result is registered and appears in the cycle after acceptance.
// Throughput: one operation per cycle unless out_tready stalls the result.
// Stall: the result register holds while out_tready is low; a new beat is
// taken only in a cycle where that register is empty or being drained.
// Reset (rst_n low, synchronous): the count clears to zero and no result is
// pending; cell contents are not cleared and are never read before written.
`timescale 1ns / 1ps

module indexed_insert_erase_list_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // opcode[2:0], position[7:3], value_in[39:8]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // value_out[31:0], count[36:32], status[38:37], 0
);

  logic [2:0]                 op;
  logic [ieil_pkg::POS_W-1:0] pos;
  logic [31:0]                val_in;
  logic                       accept;

  logic [ieil_pkg::CNT_W-1:0] count_r;
  logic [ieil_pkg::CNT_W-1:0] count_nxt;
  logic                       out_valid_r;
  logic                       out_valid_nxt;
  logic [39:0]                out_data_r;
  logic [39:0]                out_data_nxt;

  ieil_pkg::ctl_t             ctl;
  ieil_pkg::value_t           new_val;
  ieil_pkg::value_t           cell_q   [ieil_pkg::CAPACITY];
  ieil_pkg::cell_sel_t        cell_sel [ieil_pkg::CAPACITY];
  ieil_pkg::value_t           rd_val;

  assign op     = in_tdata[2:0];
  assign pos    = in_tdata[7:3];
  assign val_in = in_tdata[39:8];

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign new_val   = ieil_pkg::VALUE_WIDTH'(val_in);

  ieil_ctrl u_ctrl (
    .opcode   (op),
    .position (pos),
    .count    (count_r),
    .ctl      (ctl)
  );

  for (genvar i = 0; i < ieil_pkg::CAPACITY; i++) begin : g_cell
    ieil_pkg::value_t left_v;
    ieil_pkg::value_t right_v;

    if (i == 0) begin : g_first
      assign left_v = cell_q[i];
    end else begin : g_mid_l
      assign left_v = cell_q[i-1];
    end
    if (i == ieil_pkg::CAPACITY - 1) begin : g_last
      assign right_v = cell_q[i];
    end else begin : g_mid_r
      assign right_v = cell_q[i+1];
    end

    always_comb begin
      cell_sel[i] = ieil_pkg::SEL_HOLD;
      if (accept) begin
        case (ctl.mode)
          ieil_pkg::MODE_INS: begin
            if (ieil_pkg::CMP_W'(i) == ctl.at) begin
              cell_sel[i] = ieil_pkg::SEL_NEW;
            end else if (ieil_pkg::CMP_W'(i) > ctl.at) begin
              cell_sel[i] = ieil_pkg::SEL_LEFT;
            end
          end
          ieil_pkg::MODE_DEL: begin
            if (ieil_pkg::CMP_W'(i) >= ctl.at) begin
              cell_sel[i] = ieil_pkg::SEL_RIGHT;
            end
          end
          default: begin
          end
        endcase
      end
    end

    ieil_cell u_cell (
      .clk       (clk),
      .sel       (cell_sel[i]),
      .new_val   (new_val),
      .left_val  (left_v),
      .right_val (right_v),
      .q         (cell_q[i])
    );
  end

  // a successful read has pos below count, so the low bits index a live cell
  assign rd_val = ctl.do_read ? cell_q[pos[ieil_pkg::IDX_W-1:0]] : '0;

  always_comb begin
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (accept) begin
      count_nxt     = ctl.count_nxt;
      out_valid_nxt = 1'b1;
      out_data_nxt  = {1'b0, ctl.status, 5'(ctl.count_nxt), 32'(rd_val)};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

### rtl/core/ieil_checker.sv
// Port-level checker for the indexed insert/erase list, bound to the top level.
`timescale 1ns / 1ps

module ieil_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [39:0] in_tdata,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  // every accepted beat shows a result in the next cycle
  a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("accepted beat gave no result");

  // full status only with the list at capacity
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[38:37] == ieil_pkg::ST_FULL
      |-> out_tdata[36:32] == 5'(ieil_pkg::CAPACITY))
    else $error("full status with count below capacity");

  // a nonzero value only comes from a successful read
  a_value_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[31:0] != '0 |-> out_tdata[38:37] == ieil_pkg::ST_OK)
    else $error("value returned on a failed operation");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result pending after reset");

endmodule

bind indexed_insert_erase_list_core ieil_checker u_ieil_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

### tb/tb_indexed_insert_erase_list_core.sv
// Self-checking testbench for the indexed insert/erase list core.
`timescale 1ns / 1ps

module tb_indexed_insert_erase_list_core;

  typedef ieil_pkg::value_t value_t;

  localparam int CAPACITY = ieil_pkg::CAPACITY;

  localparam logic [2:0] OP_PUSH_FRONT = ieil_pkg::OP_PUSH_FRONT;
  localparam logic [2:0] OP_PUSH_BACK  = ieil_pkg::OP_PUSH_BACK;
  localparam logic [2:0] OP_POP_FRONT  = ieil_pkg::OP_POP_FRONT;
  localparam logic [2:0] OP_POP_BACK   = ieil_pkg::OP_POP_BACK;
  localparam logic [2:0] OP_INSERT     = ieil_pkg::OP_INSERT;
  localparam logic [2:0] OP_ERASE      = ieil_pkg::OP_ERASE;
  localparam logic [2:0] OP_READ       = ieil_pkg::OP_READ;
  localparam logic [2:0] OP_UNUSED     = 3'd7;

  localparam logic [1:0] ST_OK    = ieil_pkg::ST_OK;
  localparam logic [1:0] ST_FULL  = ieil_pkg::ST_FULL;
  localparam logic [1:0] ST_EMPTY = ieil_pkg::ST_EMPTY;
  localparam logic [1:0] ST_RANGE = ieil_pkg::ST_RANGE;

  localparam int N_RANDOM  = 1800;
  localparam int EXP_DEPTH = 4096;

  typedef struct packed {
    value_t     val;
    logic [4:0] cnt;
    logic [1:0] st;
  } list_result_t;

  typedef struct packed {
    logic [2:0]   op;
    logic [4:0]   pos;
    value_t       val;
    logic [4:0]   reps;
    logic         has_exp;
    list_result_t exp;
  } stim_row_t;

  // Typed expectations where the answer is obvious; has_exp = 0 rows use the predictor.
  localparam int N_DIR = 28;
  localparam stim_row_t DIR_TBL [N_DIR] = '{
    '{OP_POP_FRONT,  5'd0,  32'h0,         5'd1,  1'b1, '{32'h0, 5'd0,  ST_EMPTY}},
    '{OP_POP_BACK,   5'd0,  32'h0,         5'd1,  1'b1, '{32'h0, 5'd0,  ST_EMPTY}},
    '{OP_ERASE,      5'd0,  32'h0,         5'd1,  1'b1, '{32'h0, 5'd0,  ST_EMPTY}},
    '{OP_READ,       5'd31, 32'h0,         5'd1,  1'b1, '{32'h0, 5'd0,  ST_EMPTY}},
    '{OP_INSERT,     5'd1,  32'hDEAD_BEEF, 5'd1,  1'b1, '{32'h0, 5'd0,  ST_RANGE}},
    '{OP_UNUSED,     5'd31, 32'hFFFF_FFFF, 5'd1,  1'b1, '{32'h0, 5'd0,  ST_OK}},
    '{OP_PUSH_BACK,  5'd0,  32'hFFFF_FFFF, 5'd1,  1'b1, '{32'h0, 5'd1,  ST_OK}},
    '{OP_PUSH_FRONT, 5'd31, 32'h0,         5'd1,  1'b1, '{32'h0, 5'd2,  ST_OK}},
    '{OP_READ,       5'd0,  32'h1234_5678, 5'd1,  1'b1, '{32'h0, 5'd2,  ST_OK}},
    '{OP_READ,       5'd1,  32'h0,         5'd1,  1'b1, '{32'hFFFF_FFFF, 5'd2, ST_OK}},
    '{OP_READ,       5'd2,  32'h0,         5'd1,  1'b1, '{32'h0, 5'd2,  ST_RANGE}},
    '{OP_INSERT,     5'd2,  32'hA5A5_A5A5, 5'd1,  1'b1, '{32'h0, 5'd3,  ST_OK}},
    '{OP_INSERT,     5'd1,  32'h5A5A_5A5A, 5'd1,  1'b1, '{32'h0, 5'd4,  ST_OK}},
    '{OP_READ,       5'd1,  32'h0,         5'd1,  1'b1, '{32'h5A5A_5A5A, 5'd4, ST_OK}},
    '{OP_ERASE,      5'd4,  32'h0,         5'd1,  1'b1, '{32'h0, 5'd4,  ST_RANGE}},
    '{OP_ERASE,      5'd0,  32'h0,         5'd1,  1'b1, '{32'h0, 5'd3,  ST_OK}},
    '{OP_POP_FRONT,  5'd0,  32'h0,         5'd1,  1'b1, '{32'h0, 5'd2,  ST_OK}},
    '{OP_PUSH_BACK,  5'd9,  32'h8000_0000, 5'd14, 1'b0, '{32'h0, 5'd0,  ST_OK}},
    '{OP_PUSH_BACK,  5'd0,  32'h1,         5'd1,  1'b1, '{32'h0, 5'd16, ST_FULL}},
    '{OP_PUSH_FRONT, 5'd0,  32'h2,         5'd1,  1'b1, '{32'h0, 5'd16, ST_FULL}},
    '{OP_INSERT,     5'd16, 32'h3,         5'd1,  1'b1, '{32'h0, 5'd16, ST_FULL}},
    '{OP_INSERT,     5'd17, 32'h4,         5'd1,  1'b1, '{32'h0, 5'd16, ST_RANGE}},
    '{OP_INSERT,     5'd0,  32'h5,         5'd1,  1'b1, '{32'h0, 5'd16, ST_FULL}},
    '{OP_READ,       5'd15, 32'h0,         5'd1,  1'b0, '{32'h0, 5'd0,  ST_OK}},
    '{OP_ERASE,      5'd15, 32'h0,         5'd1,  1'b0, '{32'h0, 5'd0,  ST_OK}},
    '{OP_POP_BACK,   5'd0,  32'h0,         5'd15, 1'b0, '{32'h0, 5'd0,  ST_OK}},
    '{OP_POP_BACK,   5'd0,  32'h0,         5'd1,  1'b1, '{32'h0, 5'd0,  ST_EMPTY}},
    '{OP_POP_FRONT,  5'd0,  32'h0,         5'd1,  1'b1, '{32'h0, 5'd0,  ST_EMPTY}}
  };

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata   = '0;   // opcode[2:0], position[7:3], value_in[39:8]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;         // value_out[31:0], count[36:32], status[38:37], 0

  // Shadow copy of the list.
  value_t       shadow_entries [CAPACITY];
  int           shadow_count;
  // Expected result beats in order of acceptance.
  list_result_t exp_log [EXP_DEPTH];
  int           exp_wr  = 0;
  int           exp_rd  = 0;
  int           err_cnt = 0;

  indexed_insert_erase_list_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #2 clk = ~clk;

  function automatic void shadow_place(int idx, value_t v);
    for (int i = shadow_count; i > idx; i--) shadow_entries[i] = shadow_entries[i-1];
    shadow_entries[idx] = v;
    shadow_count++;
  endfunction

  function automatic void shadow_remove(int idx);
    for (int i = idx; i + 1 < shadow_count; i++) shadow_entries[i] = shadow_entries[i+1];
    shadow_count--;
  endfunction

  // Apply one operation to the shadow list and return the result beat it gives.
  function automatic list_result_t apply_list_op(logic [2:0] op, logic [4:0] pos, value_t v);
    list_result_t r;
    bit full;
    bit empty;
    r     = '0;
    r.st  = ST_OK;
    full  = shadow_count >= CAPACITY;
    empty = shadow_count == 0;
    case (op)
      OP_PUSH_FRONT: if (full) r.st = ST_FULL; else shadow_place(0, v);
      OP_PUSH_BACK:  if (full) r.st = ST_FULL; else shadow_place(shadow_count, v);
      OP_POP_FRONT:  if (empty) r.st = ST_EMPTY; else shadow_remove(0);
      OP_POP_BACK:   if (empty) r.st = ST_EMPTY; else shadow_count--;
      OP_INSERT: begin
        if (int'(pos) > shadow_count) r.st = ST_RANGE;
        else if (full) r.st = ST_FULL;
        else shadow_place(int'(pos), v);
      end
      OP_ERASE: begin
        if (empty) r.st = ST_EMPTY;
        else if (int'(pos) >= shadow_count) r.st = ST_RANGE;
        else shadow_remove(int'(pos));
      end
      OP_READ: begin
        if (empty) r.st = ST_EMPTY;
        else if (int'(pos) >= shadow_count) r.st = ST_RANGE;
        else r.val = shadow_entries[pos];
      end
      default: ;
    endcase
    r.cnt = shadow_count[4:0];
    return r;
  endfunction

  // Mostly short gaps, a few long ones.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Present one beat, hold it until accepted, then record its expected result.
  task automatic send_beat(logic [2:0] op, logic [4:0] pos, value_t v, int gap,
                           bit has_exp, list_result_t typed_exp);
    list_result_t r;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {v, pos, op};
    do @(posedge clk); while (!in_tready);
    r = apply_list_op(op, pos, v);
    exp_log[exp_wr] = has_exp ? typed_exp : r;
    exp_wr++;
  endtask

  function automatic value_t pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom;
  endfunction

  initial begin
    bit           grow;
    int           r;
    int           gap;
    logic [2:0]   op;
    logic [4:0]   pos;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIR_TBL[k]) begin
      for (int j = 0; j < int'(DIR_TBL[k].reps); j++) begin
        send_beat(DIR_TBL[k].op, DIR_TBL[k].pos, DIR_TBL[k].val + j, pick_gap(),
                  DIR_TBL[k].has_exp, DIR_TBL[k].exp);
      end
    end

    // Random walk: the count swings between empty and full so both edges get hit.
    grow = 1'b1;
    for (int i = 0; i < N_RANDOM; i++) begin
      if (shadow_count == CAPACITY && $urandom_range(0, 3) == 0) grow = 1'b0;
      else if (shadow_count == 0 && $urandom_range(0, 3) == 0) grow = 1'b1;
      else if ($urandom_range(0, 59) == 0) grow = ~grow;

      r = $urandom_range(0, 99);
      if (r < 3) op = OP_UNUSED;
      else if (r < 15) op = OP_READ;
      else if ((r < 65) == grow) op = ($urandom_range(0, 2) == 0) ? OP_INSERT :
                                      ($urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT);
      else op = ($urandom_range(0, 2) == 0) ? OP_ERASE :
                ($urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT);

      if ($urandom_range(0, 4) == 0) pos = 5'($urandom_range(0, 31));
      else if (op == OP_INSERT) pos = 5'($urandom_range(0, shadow_count));
      else if (shadow_count > 0) pos = 5'($urandom_range(0, shadow_count - 1));
      else pos = 5'($urandom_range(0, 31));

      // Run back to back through every fourth stretch.
      gap = ((i / 150) % 4 == 3) ? 0 : pick_gap();
      send_beat(op, pos, pick_value(), gap, 1'b0, '0);
    end
    in_tvalid <= 1'b0;

    while (exp_rd != exp_wr) @(posedge clk);
    repeat (8) @(posedge clk);
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Result side backpressure.
  initial begin
    int run;
    int stall;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 20);
      repeat (run) begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
      stall = pick_gap();
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    list_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (exp_rd == exp_wr) begin
        $display("%0t: unexpected result beat %h", $time, out_tdata);
        err_cnt++;
      end else begin
        want = exp_log[exp_rd];
        exp_rd++;
        if (out_tdata[31:0] !== want.val) begin
          $display("%0t: value_out expected %h actual %h", $time, want.val, out_tdata[31:0]);
          err_cnt++;
        end
        if (out_tdata[36:32] !== want.cnt) begin
          $display("%0t: count expected %0d actual %0d", $time, want.cnt, out_tdata[36:32]);
          err_cnt++;
        end
        if (out_tdata[38:37] !== want.st) begin
          $display("%0t: status expected %0d actual %0d", $time, want.st, out_tdata[38:37]);
          err_cnt++;
        end
        if (out_tdata[39] !== 1'b0) begin
          $display("%0t: pad bit expected 0 actual %b", $time, out_tdata[39]);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

### indexed_insert_erase_list_core.f
rtl/core/ieil_pkg.sv
rtl/core/ieil_cell.sv
rtl/core/ieil_ctrl.sv
rtl/core/indexed_insert_erase_list_core.sv
rtl/core/ieil_checker.sv
tb/tb_indexed_insert_erase_list_core.sv
